/* hdl/atdb_pkg.sv */
// ----------------------------------------------------------------------------
// atdb_pkg
// shared types and codes for the asymmetric timestamp debouncer
// ----------------------------------------------------------------------------
package atdb_pkg;

    // request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_WAKE   = 1'b1;

    // configuration register indexes
    localparam logic CFG_PRESS_HOLD   = 1'b0;
    localparam logic CFG_RELEASE_HOLD = 1'b1;

    localparam int unsigned HOLD_W = 16;
    localparam int unsigned TIME_W = 32;

    localparam logic [HOLD_W-1:0] PRESS_HOLD_RST   = 16'd5;
    localparam logic [HOLD_W-1:0] RELEASE_HOLD_RST = 16'd5;

    typedef struct packed {
        logic              req_type;
        logic              raw_level;
        logic [TIME_W-1:0] time_ms;
    } t_in_word;

    typedef struct packed {
        logic level_changed;
        logic stable_level;
        logic bounce_filtered;
    } t_out_word;

    typedef struct packed {
        logic [HOLD_W-1:0] press_hold_ms;
        logic [HOLD_W-1:0] release_hold_ms;
    } t_hold_cfg;

endpackage

/* hdl/atdb_core.sv */
// ----------------------------------------------------------------------------
// atdb_core
// debounce state and per-word decision logic
// ----------------------------------------------------------------------------
module atdb_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  atdb_pkg::t_in_word  i_item,
    input  atdb_pkg::t_hold_cfg i_hold,
    output atdb_pkg::t_out_word o_result
);
    import atdb_pkg::*;

    logic              r_started;
    logic              r_settled;
    logic              r_pending;
    logic [TIME_W-1:0] r_since;

    logic              n_started;
    logic              n_settled;
    logic              n_pending;
    logic [TIME_W-1:0] n_since;

    logic [TIME_W-1:0] elapsed;
    logic [HOLD_W-1:0] hold;
    logic              held;
    logic              changed;
    logic              filtered;

    // wrapping elapsed time against the hold of the pending level
    assign elapsed = i_item.time_ms - r_since;
    assign hold    = r_pending ? i_hold.press_hold_ms : i_hold.release_hold_ms;
    assign held    = elapsed >= {{(TIME_W-HOLD_W){1'b0}}, hold};

    always_comb begin
        n_started = r_started;
        n_settled = r_settled;
        n_pending = r_pending;
        n_since   = r_since;
        changed   = 1'b0;
        filtered  = 1'b0;
        if (!r_started) begin
            n_started = 1'b1;
            n_settled = i_item.raw_level;
            n_pending = i_item.raw_level;
            n_since   = i_item.time_ms;
        end else if (i_item.req_type == REQ_WAKE) begin
            changed   = r_settled != i_item.raw_level;
            n_settled = i_item.raw_level;
            n_pending = i_item.raw_level;
            n_since   = i_item.time_ms;
        end else if (i_item.raw_level != r_pending) begin
            if (r_pending != r_settled) begin
                if (held) begin
                    n_settled = r_pending;
                    changed   = 1'b1;
                end else begin
                    filtered  = 1'b1;
                end
            end
            n_pending = i_item.raw_level;
            n_since   = i_item.time_ms;
        end else if (r_pending != r_settled && held) begin
            n_settled = r_pending;
            changed   = 1'b1;
        end
    end

    assign o_result.level_changed   = changed;
    assign o_result.stable_level    = n_settled;
    assign o_result.bounce_filtered = filtered;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_settled <= 1'b0;
            r_pending <= 1'b0;
            r_since   <= '0;
        end else if (i_step) begin
            r_started <= n_started;
            r_settled <= n_settled;
            r_pending <= n_pending;
            r_since   <= n_since;
        end
    end

    a_started_after_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> r_started)
        else $error("state not initialized after a word");

    a_first_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !r_started) |-> (!o_result.level_changed && !o_result.bounce_filtered))
        else $error("first word reported a change or bounce");

    a_change_xor_bounce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |-> !(o_result.level_changed && o_result.bounce_filtered))
        else $error("change and bounce on the same word");

    a_settled_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_started) |=> (r_settled == $past(r_settled)) == !$past(changed))
        else $error("settled level moved without a change flag");

endmodule

/* hdl/asymmetric_timestamp_debouncer_unit.sv */
// ----------------------------------------------------------------------------
// asymmetric_timestamp_debouncer_unit
// key debouncer with separate press and release hold times on ms timestamps
// ----------------------------------------------------------------------------
// usage
//   input channel: one word per key sample (request kind, raw level, time_ms),
//   taken when i_in_valid is high and o_in_stall is low
//   output channel: one result word per input word (level_changed,
//   stable_level, bounce_filtered), taken when o_out_valid is high and
//   i_out_stall is low; results come out in input order
//   config channel: i_cfg_index 0 writes press_hold_ms, 1 writes
//   release_hold_ms; o_cfg_ready is always high, write only while idle
// timing
//   a word is registered on acceptance, evaluated against the debounce state
//   once the result stage is empty or draining, and its result registered
//   in the result stage; one word per cycle sustained while the receiver
//   does not stall; the state update (one 32-bit subtract and compare) sits
//   in that single stage
// reset and stall
//   synchronous active-low reset empties both stages, clears the debounce
//   state to "not started" and loads both hold times with 5 ms
//   while the receiver stalls with a result waiting, the input stage holds
//   one more word and then stalls the sender; nothing is dropped
// ----------------------------------------------------------------------------
module asymmetric_timestamp_debouncer_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input words
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  atdb_pkg::t_in_word   i_in_data,
    // result words
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output atdb_pkg::t_out_word  o_out_data,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [15:0]          i_cfg_data
);
    import atdb_pkg::*;

    // hold time registers
    t_hold_cfg r_hold;

    // input stage
    logic      r_in_valid;
    t_in_word  r_in;

    // result stage
    logic      r_out_valid;
    t_out_word r_out;

    logic      step;
    t_out_word n_out;

    // the input stage moves on when the result stage is empty or draining
    assign step        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !step;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold.press_hold_ms   <= PRESS_HOLD_RST;
            r_hold.release_hold_ms <= RELEASE_HOLD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PRESS_HOLD:   r_hold.press_hold_ms   <= i_cfg_data;
                CFG_RELEASE_HOLD: r_hold.release_hold_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register: load whenever it is empty or being emptied
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // decision logic and debounce state
    atdb_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .i_hold   (r_hold),
        .o_result (n_out)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result lost or changed");

    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("evaluated word produced no result");

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the asymmetric timestamp debouncer: directed edge
// cases on hold times and timestamp wrap, then randomized key-bounce traffic
// under several hold settings, checked word by word against a local predictor
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import atdb_pkg::*;

    localparam int unsigned RUN_LIMIT   = 400000;  // cycles before giving up
    localparam int unsigned HOLD_CYCLES = 60;      // long receiver hold-off
    localparam int unsigned IDLE_PCT    = 33;

    // dut signals, all inputs known from time zero
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_data;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic      i_cfg_index = CFG_PRESS_HOLD;
    logic [15:0] i_cfg_data = '0;

    // predictor copy of the key state and hold registers
    logic              key_started;
    logic              key_settled;
    logic              key_pending;
    logic [TIME_W-1:0] key_pending_since;
    logic [HOLD_W-1:0] cfg_press_hold;
    logic [HOLD_W-1:0] cfg_release_hold;

    // results owed by the block, oldest first
    t_out_word debounce_reports_due[$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // traffic shaping, updated by the test sequence with nonblocking writes
    logic        sender_jitter   = 1'b1;
    logic        receiver_jitter = 1'b1;
    int unsigned hold_trigger    = 0;
    int unsigned hold_seen       = 0;
    int unsigned hold_left       = 0;

    // random stimulus state: running timestamp and last raw key level
    logic [TIME_W-1:0] stim_clock;
    logic              stim_raw;

    asymmetric_timestamp_debouncer_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // (re)start the key state on a raw level, as on first word or wake
    function automatic void restart_key(input logic level, input logic [TIME_W-1:0] now);
        key_started       = 1'b1;
        key_settled       = level;
        key_pending       = level;
        key_pending_since = now;
    endfunction

    // advance the key state by one input word and return the result it owes
    function automatic t_out_word next_debounce_report(input t_in_word w);
        t_out_word         rpt;
        logic [TIME_W-1:0] elapsed;
        logic [HOLD_W-1:0] need;
        logic              ripe;
        rpt     = '0;
        // elapsed time wraps modulo 2^32, so an earlier stamp reads as very long
        elapsed = w.time_ms - key_pending_since;
        need    = key_pending ? cfg_press_hold : cfg_release_hold;
        ripe    = (elapsed >= {{(TIME_W-HOLD_W){1'b0}}, need});
        if (!key_started) begin
            restart_key(w.raw_level, w.time_ms);
        end else if (w.req_type == REQ_WAKE) begin
            rpt.level_changed = (key_settled != w.raw_level);
            restart_key(w.raw_level, w.time_ms);
        end else if (w.raw_level != key_pending) begin
            // candidate replaced: settle it if ripe, else count a bounce
            if (key_pending != key_settled) begin
                if (ripe) begin
                    key_settled       = key_pending;
                    rpt.level_changed = 1'b1;
                end else begin
                    rpt.bounce_filtered = 1'b1;
                end
            end
            key_pending       = w.raw_level;
            key_pending_since = w.time_ms;
        end else if (key_pending != key_settled && ripe) begin
            key_settled       = key_pending;
            rpt.level_changed = 1'b1;
        end
        rpt.stable_level = key_settled;
        return rpt;
    endfunction

    // ------------------------------------------------------------------------
    // result checker: every accepted result word against the oldest owed one
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_word owed;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (debounce_reports_due.size() == 0) begin
                mismatch_count++;
                $display("%0t: result word with none owed, got %b", $time, o_out_data);
            end else begin
                owed = debounce_reports_due.pop_front();
                if (o_out_data.level_changed !== owed.level_changed) begin
                    mismatch_count++;
                    $display("%0t: level_changed expected %b, got %b",
                             $time, owed.level_changed, o_out_data.level_changed);
                end
                if (o_out_data.stable_level !== owed.stable_level) begin
                    mismatch_count++;
                    $display("%0t: stable_level expected %b, got %b",
                             $time, owed.stable_level, o_out_data.stable_level);
                end
                if (o_out_data.bounce_filtered !== owed.bounce_filtered) begin
                    mismatch_count++;
                    $display("%0t: bounce_filtered expected %b, got %b",
                             $time, owed.bounce_filtered, o_out_data.bounce_filtered);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls, or a long counted hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen   <= hold_trigger;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= receiver_jitter && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sender side; every task is entered and left at a falling edge
    // ------------------------------------------------------------------------

    // offer one word, keep it steady until taken, then book its result
    task automatic send_word(input t_in_word w);
        while (sender_jitter && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        debounce_reports_due.push_back(next_debounce_report(w));
        @(negedge i_clk);
    endtask

    task automatic sample(input logic kind, input logic raw, input logic [TIME_W-1:0] t);
        t_in_word w;
        w.req_type  = kind;
        w.raw_level = raw;
        w.time_ms   = t;
        send_word(w);
    endtask

    // stop offering and wait until every owed result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (debounce_reports_due.size() != 0) @(negedge i_clk);
        // pipeline is two stages deep
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_hold(input logic idx, input logic [HOLD_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_PRESS_HOLD) begin
            cfg_press_hold = val;
        end else begin
            cfg_release_hold = val;
        end
        @(negedge i_clk);
    endtask

    // both hold registers, only with the block idle
    task automatic set_holds(input logic [HOLD_W-1:0] press_ms,
                             input logic [HOLD_W-1:0] rel_ms);
        drain_results();
        write_hold(CFG_PRESS_HOLD, press_ms);
        write_hold(CFG_RELEASE_HOLD, rel_ms);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // bouncy key traffic: mostly small forward steps around the hold times,
    // some repeats of the same ms, a few steps back in time and random jumps
    task automatic run_random_phase(input int unsigned n_words);
        t_in_word    w;
        int unsigned span;
        int unsigned near;
        int unsigned pick;
        span = ((cfg_press_hold > cfg_release_hold) ? cfg_press_hold : cfg_release_hold) + 2;
        near = (span > 64) ? 64 : span;
        repeat (n_words) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                stim_clock = stim_clock + $urandom_range(0, near);
            end else if (pick < 80) begin
                stim_clock = stim_clock + $urandom_range(0, 2 * span);
            end else if (pick < 92) begin
                stim_clock = stim_clock;
            end else if (pick < 97) begin
                stim_clock = stim_clock - $urandom_range(1, 50);
            end else begin
                stim_clock = $urandom();
            end
            if ($urandom_range(0, 99) < 35) stim_raw = ~stim_raw;
            w.req_type  = ($urandom_range(0, 99) < 5) ? REQ_WAKE : REQ_SAMPLE;
            w.raw_level = stim_raw;
            w.time_ms   = stim_clock;
            send_word(w);
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset holds of 5 ms; first word, bounce, exact boundary, wrap, wake
    task automatic test_directed_edges();
        sample(REQ_SAMPLE, 1'b1, 32'hFFFF_FFFC);  // first word only initializes
        sample(REQ_SAMPLE, 1'b0, 32'hFFFF_FFFD);  // new candidate
        sample(REQ_SAMPLE, 1'b1, 32'hFFFF_FFFE);  // dropped too early
        sample(REQ_SAMPLE, 1'b0, 32'hFFFF_FFFF);  // candidate again
        sample(REQ_SAMPLE, 1'b0, 32'h0000_0003);  // wrapped, 4 ms, not yet
        sample(REQ_SAMPLE, 1'b0, 32'h0000_0004);  // exactly 5 ms, settles
        sample(REQ_SAMPLE, 1'b1, 32'h0000_0004);
        sample(REQ_SAMPLE, 1'b0, 32'h0000_0014);  // ripe candidate replaced
        sample(REQ_SAMPLE, 1'b0, 32'h0000_000A);  // stamp goes back: long elapsed
        sample(REQ_WAKE,   1'b1, 32'h0000_0000);
        sample(REQ_WAKE,   1'b1, 32'hFFFF_FFFF);  // wake with same level
        sample(REQ_WAKE,   1'b0, 32'h8000_0000);
        sample(REQ_SAMPLE, 1'b0, 32'h7FFF_FFFF);
        sample(REQ_SAMPLE, 1'b1, 32'h5555_5555);
        sample(REQ_SAMPLE, 1'b1, 32'hAAAA_AAAA);
    endtask

    // zero hold: a candidate settles on the next word that sees it
    task automatic test_zero_hold();
        set_holds(16'd0, 16'd0);
        sample(REQ_SAMPLE, 1'b0, 32'h0000_1000);
        sample(REQ_SAMPLE, 1'b0, 32'h0000_1000);
        sample(REQ_SAMPLE, 1'b1, 32'h0000_1000);
        sample(REQ_SAMPLE, 1'b0, 32'h0000_1000);  // candidate replaced at 0 ms
    endtask

    // largest hold on one side, zero on the other, both ways round
    task automatic test_hold_extremes();
        set_holds(16'hFFFF, 16'd0);
        sample(REQ_SAMPLE, 1'b1, 32'h0001_0000);
        sample(REQ_SAMPLE, 1'b1, 32'h0001_FFFE);  // one short of the hold
        sample(REQ_SAMPLE, 1'b1, 32'h0001_FFFF);  // exactly the hold
        set_holds(16'd0, 16'hFFFF);
        sample(REQ_SAMPLE, 1'b0, 32'hFFFF_0000);
        sample(REQ_SAMPLE, 1'b1, 32'hFFFF_FFFE);  // bounce below 65535 ms
        sample(REQ_SAMPLE, 1'b1, 32'hFFFF_FFFF);
    endtask

    // random traffic across several hold settings
    task automatic test_random_holds();
        logic [HOLD_W-1:0] press_set[8];
        logic [HOLD_W-1:0] rel_set[8];
        press_set = '{16'd5, 16'd0, 16'd1, 16'd3, 16'd40, 16'hFFFF, 16'd0, 16'd0};
        rel_set   = '{16'd5, 16'd0, 16'd1, 16'd40, 16'd3, 16'hFFFF, 16'd0, 16'd0};
        press_set[6] = 16'($urandom_range(0, 200));
        rel_set[6]   = 16'($urandom_range(0, 200));
        press_set[7] = 16'($urandom_range(0, 16'hFFFF));
        rel_set[7]   = 16'($urandom_range(0, 20));
        stim_clock = $urandom();
        stim_raw   = 1'($urandom_range(0, 1));
        for (int k = 0; k < 8; k++) begin
            set_holds(press_set[k], rel_set[k]);
            run_random_phase(160);
        end
    endtask

    // long stretch with neither side idling
    task automatic test_steady_stream();
        drain_results();
        sender_jitter   <= 1'b0;
        receiver_jitter <= 1'b0;
        @(negedge i_clk);
        run_random_phase(100);
        sender_jitter   <= 1'b1;
        receiver_jitter <= 1'b1;
        drain_results();
    endtask

    // receiver holds off while the sender keeps offering, so the block fills
    // up and stalls its input; then the sender waits for everything owed
    task automatic test_backpressure();
        set_holds(16'd2, 16'd7);
        sender_jitter <= 1'b0;
        hold_trigger  <= hold_trigger + 1;
        @(negedge i_clk);
        run_random_phase(30);
        sender_jitter <= 1'b1;
        drain_results();
    endtask

    initial begin
        cfg_press_hold    = PRESS_HOLD_RST;
        cfg_release_hold  = RELEASE_HOLD_RST;
        key_started       = 1'b0;
        key_settled       = 1'b0;
        key_pending       = 1'b0;
        key_pending_since = '0;
        stim_clock        = '0;
        stim_raw          = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_edges();
        test_zero_hold();
        test_hold_extremes();
        test_random_holds();
        test_steady_stream();
        test_backpressure();

        drain_results();
        if (mismatch_count == 0 && debounce_reports_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/atdb_pkg.sv
hdl/atdb_core.sv
hdl/asymmetric_timestamp_debouncer_unit.sv
dv/testbench.sv
